/* hdl/bcme_pkg.sv */
// Package for the button chord MIDI encoder: status codes, register indexes,
// chord table and the tick descriptor passed from the front to the back part.
// No dependencies.
`timescale 1ns / 1ps

package bcme_pkg;

  localparam int NUM_BTN     = 6;
  localparam int NUM_CHORD   = 6;
  localparam int NUM_SEG     = 5;   // target and direction buttons
  localparam int NUM_REG     = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_CC        = 8'hB0;
  localparam logic [7:0] ST_KIND_MASK = 8'hF0;
  localparam logic [6:0] VEL_FULL     = 7'd127;

  typedef enum logic [2:0] {
    REG_CUE_REW  = 3'd0,
    REG_BAR_REW  = 3'd1,
    REG_BEAT_REW = 3'd2,
    REG_CUE_FWD  = 3'd3,
    REG_BAR_FWD  = 3'd4,
    REG_BEAT_FWD = 3'd5,
    REG_LOOP_CC  = 3'd6,
    REG_LED_CC   = 3'd7
  } reg_idx_t;

  localparam logic [6:0] REG_RESET [NUM_REG] = '{
    7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd100, 7'd64
  };

  // Chord k is sounded by its target button together with its direction button.
  localparam logic [2:0] CHORD_TARGET [NUM_CHORD] = '{
    3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3
  };
  localparam logic [2:0] CHORD_DIR [NUM_CHORD] = '{
    3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
  };

  // One tick as the back part replays it: an optional loop CC first, then one
  // chord mask per target or direction button in button order.
  typedef struct packed {
    logic                           cc;
    logic                           cc_val;
    logic                           led;
    logic [NUM_SEG-1:0]             seg_on;
    logic [NUM_SEG-1:0][NUM_CHORD-1:0] seg_mask;
  } tick_t;

  function automatic logic [NUM_CHORD-1:0] chord_members(input logic [2:0] btn);
    logic [NUM_CHORD-1:0] m;
    m = '0;
    for (int k = 0; k < NUM_CHORD; k++) begin
      m[k] = (CHORD_TARGET[k] == btn) || (CHORD_DIR[k] == btn);
    end
    return m;
  endfunction

endpackage

/* hdl/bcme_front.sv */
// Front part of the button chord MIDI encoder: takes one scan tick, updates
// button, chord and LED state and writes a tick descriptor. Uses bcme_pkg.
`timescale 1ns / 1ps

module bcme_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,
  input  logic             s_tuser,
  input  logic [6:0]       led_cc,
  input  logic             full,
  output logic             push,
  output bcme_pkg::tick_t  tick
);
  import bcme_pkg::*;

  logic [NUM_BTN-1:0]   held;
  logic [NUM_CHORD-1:0] active;
  logic                 led;
  logic [NUM_BTN-1:0]   held_next;
  logic [NUM_CHORD-1:0] active_next;
  logic                 led_next;

  logic [NUM_BTN-1:0] pressed;
  logic [7:0]         in_status;
  logic [7:0]         in_data1;
  logic [7:0]         in_data2;

  assign pressed   = ~s_tdata[5:0];
  assign in_status = s_tdata[13:6];
  assign in_data1  = s_tdata[21:14];
  assign in_data2  = s_tdata[29:22];

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    logic [NUM_CHORD-1:0] mask;
    held_next   = held;
    active_next = active;
    led_next    = led;
    tick        = '0;
    mask        = '0;

    if (s_tuser && ((in_status & ST_KIND_MASK) == ST_CC) && (in_data1 == {1'b0, led_cc})) begin
      led_next = (in_data2 != 8'd0);
    end

    // Loop button reports the LED as it was, then toggles it.
    if (pressed[0] && !held[0]) begin
      held_next[0] = 1'b1;
      tick.cc      = 1'b1;
      tick.cc_val  = led_next;
      led_next     = !led_next;
    end else if (!pressed[0] && held[0]) begin
      held_next[0] = 1'b0;
    end

    for (int b = 1; b < NUM_BTN; b++) begin
      mask = '0;
      if (pressed[b] && !held[b]) begin
        held_next[b] = 1'b1;
        for (int k = 0; k < NUM_CHORD; k++) begin
          if (held_next[CHORD_TARGET[k]] && held_next[CHORD_DIR[k]] && !active_next[k]) begin
            mask[k] = 1'b1;
          end
        end
        active_next        = active_next | mask;
        tick.seg_on[b-1]   = 1'b1;
        tick.seg_mask[b-1] = mask;
      end else if (!pressed[b] && held[b]) begin
        held_next[b]       = 1'b0;
        mask               = active_next & chord_members(3'(b));
        active_next        = active_next & ~mask;
        tick.seg_mask[b-1] = mask;
      end
    end

    tick.led = led_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      active <= '0;
      led    <= 1'b0;
    end else if (push) begin
      held   <= held_next;
      active <= active_next;
      led    <= led_next;
    end
  end

endmodule

/* hdl/bcme_queue.sv */
// Two-entry queue of tick descriptors between the front and back parts.
// Uses bcme_pkg.
`timescale 1ns / 1ps

module bcme_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bcme_pkg::tick_t  din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output bcme_pkg::tick_t  dout
);
  import bcme_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/bcme_back.sv */
// Back part of the button chord MIDI encoder: replays one tick descriptor as
// a run of MIDI message items, one per cycle unless m_tready stalls the
// output, into an output register. Uses bcme_pkg.
`timescale 1ns / 1ps

module bcme_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  bcme_pkg::tick_t                        q_tick,
  output logic                                   q_pop,
  input  logic [bcme_pkg::NUM_CHORD-1:0][6:0]    notes,
  input  logic [6:0]                             loop_cc,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [23:0]                            m_tdata,
  output logic                                   m_tuser,
  output logic                                   m_tlast
);
  import bcme_pkg::*;

  tick_t work;
  tick_t work_next;
  logic  work_valid;

  logic       issue;
  logic       last_item;
  logic       msg_valid;
  logic [7:0] msg_status;
  logic [6:0] msg_data1;
  logic [6:0] msg_data2;

  assign issue = work_valid && (!m_tvalid || m_tready);

  always_comb begin
    logic [2:0] seg;
    logic [2:0] bit_sel;
    logic       any_seg;
    work_next  = work;
    msg_valid  = 1'b0;
    msg_status = '0;
    msg_data1  = '0;
    msg_data2  = '0;
    seg        = '0;
    bit_sel    = '0;
    any_seg    = |work.seg_mask;

    for (int s = NUM_SEG - 1; s >= 0; s--) begin
      if (work.seg_mask[s] != '0) begin
        seg = 3'(s);
      end
    end
    for (int k = NUM_CHORD - 1; k >= 0; k--) begin
      if (work.seg_mask[seg][k]) begin
        bit_sel = 3'(k);
      end
    end

    if (work.cc) begin
      msg_valid    = 1'b1;
      msg_status   = ST_CC;
      msg_data1    = loop_cc;
      msg_data2    = work.cc_val ? VEL_FULL : 7'd0;
      work_next.cc = 1'b0;
    end else if (any_seg) begin
      msg_valid  = 1'b1;
      msg_status = work.seg_on[seg] ? ST_NOTE_ON : ST_NOTE_OFF;
      msg_data1  = notes[bit_sel];
      msg_data2  = work.seg_on[seg] ? VEL_FULL : 7'd0;
      work_next.seg_mask[seg][bit_sel] = 1'b0;
    end

    last_item = !(work_next.cc || (|work_next.seg_mask));
  end

  assign q_pop = q_valid && (!work_valid || (issue && last_item));

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (q_pop) begin
      work_valid <= 1'b1;
    end else if (issue && last_item) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_tick;
    end else if (issue) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (issue) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_tdata <= {1'b0, work.led, msg_data2, msg_data1, msg_status};
      m_tuser <= msg_valid;
      m_tlast <= last_item;
    end
  end

endmodule

/* hdl/button_chord_midi_encoder.sv */
// Top level of the button chord MIDI encoder: configuration registers and the
// front part, tick queue and back part. Uses bcme_pkg, bcme_front,
// bcme_queue and bcme_back.
`timescale 1ns / 1ps

// Each input item is one button scan tick: six active-low button levels and
// an optional incoming MIDI message. The block answers with a run of result
// items, the final one marked by m_tlast. An incoming control change on the
// LED controller number sets the loop LED; a loop press sends a control
// change reporting the LED and toggles it; holding a target button (cue, bar,
// beat) with a direction button (rewind, forward) sounds one note per chord
// and releasing either button silences it. A tick that causes no message
// gives one item with the message flag low. The front part digests a tick in
// the cycle it is accepted and hands a compact descriptor to a two-entry
// queue; the back part then sends one result item per cycle unless m_tready
// stalls it, so a tick gives max(1, n) items, n being its message count (at
// most 13); the first item passes the queue, work and output registers.
// Ticks are accepted back to back while the queue has room. Configuration
// must be written only while the block is idle; the block does not enforce this.
module button_chord_midi_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] loop_btn_n, [1] cue_btn_n, [2] bar_btn_n, [3] beat_btn_n,
  // [4] rewind_btn_n, [5] forward_btn_n, [13:6] midi_in_status,
  // [21:14] midi_in_data1, [29:22] midi_in_data2, [31:30] zero
  input  logic [31:0] s_tdata,
  // [0] midi_in_valid
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] msg_status, [14:8] msg_data1, [21:15] msg_data2, [22] led_on,
  // [23] zero
  output logic [23:0] m_tdata,
  // [0] msg_valid
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import bcme_pkg::*;

  // Chord notes in chord order, then the two controller numbers.
  logic [NUM_CHORD-1:0][6:0] notes;
  logic [6:0]                loop_cc;
  logic [6:0]                led_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHORD; k++) begin
        notes[k] <= REG_RESET[k];
      end
      loop_cc <= REG_RESET[REG_LOOP_CC];
      led_cc  <= REG_RESET[REG_LED_CC];
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CUE_REW:  notes[0] <= cfg_data;
        REG_BAR_REW:  notes[1] <= cfg_data;
        REG_BEAT_REW: notes[2] <= cfg_data;
        REG_CUE_FWD:  notes[3] <= cfg_data;
        REG_BAR_FWD:  notes[4] <= cfg_data;
        REG_BEAT_FWD: notes[5] <= cfg_data;
        REG_LOOP_CC:  loop_cc  <= cfg_data;
        REG_LED_CC:   led_cc   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tick_t front_tick;
  tick_t queue_tick;
  logic  push;
  logic  pop;
  logic  full;
  logic  queue_valid;

  // The front part classifies the tick and updates the button state.
  bcme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .led_cc   (led_cc),
    .full     (full),
    .push     (push),
    .tick     (front_tick)
  );

  // The queue lets the front keep taking ticks while messages drain.
  bcme_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_tick),
    .full  (full),
    .pop   (pop),
    .valid (queue_valid),
    .dout  (queue_tick)
  );

  // The back part serializes each descriptor into message items.
  bcme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (queue_valid),
    .q_tick   (queue_tick),
    .q_pop    (pop),
    .notes    (notes),
    .loop_cc  (loop_cc),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* hdl/bcme_checker.sv */
// Port-level checks for the button chord MIDI encoder, attached to the top
// level by the bind statement at the end. Uses bcme_pkg.
`timescale 1ns / 1ps

module bcme_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import bcme_pkg::*;

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output item offered right after reset");

  // A stalled item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // A quiet tick gives a single empty item that ends the run.
  a_quiet_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[21:0] == 22'd0))
    else $error("empty item is not a lone final item");

  // Messages carry only note on, note off or control change.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[7:0] == ST_NOTE_ON) ||
      (m_tdata[7:0] == ST_NOTE_OFF) || (m_tdata[7:0] == ST_CC))
    else $error("unexpected status byte");

endmodule

bind button_chord_midi_encoder bcme_checker u_bcme_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
